FILE: src/uenc_pkg.sv
// shared types, constants and the utf-8 byte encoder for the utf-16 to utf-8 encoder
package uenc_pkg;

	localparam int unsigned JOB_BYTES = 6;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST = 16'hDC00;
	localparam logic [15:0] LOW_LAST = 16'hDFFF;
	localparam logic [20:0] PLANE_BASE = 21'h10000;
	localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
	localparam logic [20:0] MAX_ONE = 21'h00007F;
	localparam logic [20:0] MAX_TWO = 21'h0007FF;
	localparam logic [20:0] MAX_THREE = 21'h00FFFF;
	localparam logic [7:0] LEAD_TWO = 8'hC0;
	localparam logic [7:0] LEAD_THREE = 8'hE0;
	localparam logic [7:0] LEAD_FOUR = 8'hF0;
	localparam logic [7:0] CONT = 8'h80;

	typedef logic [JOB_BYTES-1:0][7:0] job_bytes_t;

	typedef struct packed {
		job_bytes_t bytes;
		logic [2:0] count;
	} job_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0] count;
	} cp_bytes_t;

	function automatic cp_bytes_t encode_cp(input logic [20:0] cp);
		cp_bytes_t r;
		r.bytes = '0;
		if (cp <= MAX_ONE) begin
			r.bytes[0] = {1'b0, cp[6:0]};
			r.count = 3'd1;
		end else if (cp <= MAX_TWO) begin
			r.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
			r.bytes[1] = CONT | {2'b00, cp[5:0]};
			r.count = 3'd2;
		end else if (cp <= MAX_THREE) begin
			r.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
			r.bytes[1] = CONT | {2'b00, cp[11:6]};
			r.bytes[2] = CONT | {2'b00, cp[5:0]};
			r.count = 3'd3;
		end else begin
			r.bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
			r.bytes[1] = CONT | {2'b00, cp[17:12]};
			r.bytes[2] = CONT | {2'b00, cp[11:6]};
			r.bytes[3] = CONT | {2'b00, cp[5:0]};
			r.count = 3'd4;
		end
		return r;
	endfunction

endpackage

FILE: src/utf16_to_utf8_encoder.sv
// top level of the utf-16 to utf-8 encoder
//   channel  direction  handshake             payload
//   in       into block in_valid / in_stall   code_unit[15:0], end_of_string
//   out      from block out_valid / out_stall out_byte[7:0], run_last
// one output byte per cycle while out_stall is low; a word gives 0 to 6 bytes (mostly 1 to 3)
// a word is taken every cycle while the two-entry job queue has room
// a word's first byte passes the queue entry, the job register and the output register
// arst_n clears the held surrogate, the queue and the output valid flag
// out_stall holds the output register; in_stall rises only when the queue is full
module utf16_to_utf8_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        run_last
);

	logic queue_full;
	logic push;
	logic pop;
	logic head_valid;
	uenc_pkg::job_t push_job;
	uenc_pkg::job_t head_job;

	uenc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.code_unit     (code_unit),
		.end_of_string (end_of_string),
		.queue_full    (queue_full),
		.push          (push),
		.job           (push_job)
	);

	uenc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	uenc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last)
	);

endmodule

FILE: src/uenc_front.sv
// front end: classifies code units, pairs surrogates and builds byte jobs
module uenc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [15:0]     code_unit,
	input  logic            end_of_string,
	input  logic            queue_full,
	output logic            push,
	output uenc_pkg::job_t  job
);

	logic [9:0] held_high_q;
	logic held_valid_q;
	logic accept;
	logic is_high;
	logic is_low;
	logic pre_fffd;
	logic cp_valid;
	logic hold_next;
	logic [20:0] cp;
	uenc_pkg::cp_bytes_t fffd_enc;
	uenc_pkg::cp_bytes_t cp_enc;
	uenc_pkg::job_bytes_t cp_part;

	assign in_stall = queue_full;
	assign accept = in_valid && !queue_full;
	assign is_high = (code_unit >= uenc_pkg::HIGH_FIRST) && (code_unit <= uenc_pkg::HIGH_LAST);
	assign is_low = (code_unit >= uenc_pkg::LOW_FIRST) && (code_unit <= uenc_pkg::LOW_LAST);

	always_comb begin
		pre_fffd = 1'b0;
		cp_valid = 1'b1;
		hold_next = 1'b0;
		cp = {5'b00000, code_unit};
		if (held_valid_q && is_low) begin
			cp = uenc_pkg::PLANE_BASE + {1'b0, held_high_q, code_unit[9:0]};
		end else begin
			pre_fffd = held_valid_q;
			if (is_high) begin
				if (end_of_string) begin
					cp = uenc_pkg::REPLACEMENT;
				end else begin
					cp_valid = 1'b0;
					hold_next = 1'b1;
				end
			end else if (is_low) begin
				cp = uenc_pkg::REPLACEMENT;
			end
		end
	end

	assign fffd_enc = uenc_pkg::encode_cp(uenc_pkg::REPLACEMENT);
	assign cp_enc = uenc_pkg::encode_cp(cp);
	assign cp_part = pre_fffd ? {cp_enc.bytes[2:0], 24'h0} : {16'h0, cp_enc.bytes};

	always_comb begin
		job.bytes = '0;
		job.count = 3'd0;
		if (cp_valid) begin
			job.bytes = cp_part;
			job.count = cp_enc.count;
		end
		if (pre_fffd) begin
			job.bytes[2:0] = fffd_enc.bytes[2:0];
			job.count = job.count + fffd_enc.count;
		end
	end

	assign push = accept && (pre_fffd || cp_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_high_q <= '0;
		end else if (accept) begin
			held_valid_q <= hold_next;
			held_high_q <= hold_next ? code_unit[9:0] : 10'd0;
		end
	end

endmodule

FILE: src/uenc_fifo.sv
// two-entry job queue between front and back
module uenc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  uenc_pkg::job_t  push_job,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output uenc_pkg::job_t  head_job
);

	uenc_pkg::job_t mem_q [uenc_pkg::QUEUE_DEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == 2'(uenc_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != 2'd0);
	assign head_job = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: src/uenc_back.sv
// back end: serializes each job one byte per cycle into the output register while out_stall is low
module uenc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  uenc_pkg::job_t  head_job,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      out_byte,
	output logic            run_last
);

	uenc_pkg::job_bytes_t cur_bytes_q;
	logic [2:0] rem_q;
	logic cur_valid_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic run_last_q;
	logic adv;
	logic cur_done;

	assign adv = !out_valid_q || !out_stall;
	assign cur_done = adv && cur_valid_q && (rem_q == 3'd1);
	assign pop = head_valid && (!cur_valid_q || cur_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			rem_q <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= cur_valid_q;
			end
			if (pop) begin
				cur_valid_q <= 1'b1;
				rem_q <= head_job.count;
			end else if (adv && cur_valid_q) begin
				rem_q <= rem_q - 3'd1;
				if (rem_q == 3'd1) begin
					cur_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cur_valid_q) begin
			out_byte_q <= cur_bytes_q[0];
			run_last_q <= (rem_q == 3'd1);
		end
		if (pop) begin
			cur_bytes_q <= head_job.bytes;
		end else if (adv && cur_valid_q) begin
			cur_bytes_q <= {8'h00, cur_bytes_q[uenc_pkg::JOB_BYTES-1:1]};
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign run_last = run_last_q;

endmodule

FILE: tb/tb_utf16_to_utf8_encoder.sv
// testbench for the utf-16 to utf-8 encoder: a directed table, then random words, every byte checked
module tb_utf16_to_utf8_encoder;

	localparam int N_DIR = 25;
	localparam int RANDOM_WORDS = 75;
	localparam int LONG_HOLD = 80;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic [15:0] unit;
		logic eos;
		logic typed;
		logic [2:0] count;
		logic [47:0] bytes;
	} dir_row_t;

	typedef struct packed {
		logic [7:0] data;
		logic last;
	} utf8_out_t;

	// typed rows give their bytes first byte leftmost
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{16'h0000, 1'b0, 1'b1, 3'd1, 48'h0000_0000_0000},
		'{16'h007F, 1'b0, 1'b1, 3'd1, 48'h7F00_0000_0000},
		'{16'h0080, 1'b0, 1'b1, 3'd2, 48'hC280_0000_0000},
		'{16'h07FF, 1'b0, 1'b1, 3'd2, 48'hDFBF_0000_0000},
		'{16'h0800, 1'b0, 1'b1, 3'd3, 48'hE0A0_8000_0000},
		'{16'hFFFF, 1'b1, 1'b1, 3'd3, 48'hEFBF_BF00_0000},
		'{16'hD800, 1'b0, 1'b1, 3'd0, 48'h0000_0000_0000},
		'{16'hDC00, 1'b0, 1'b1, 3'd4, 48'hF090_8080_0000},
		'{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h0000_0000_0000},
		'{16'hDFFF, 1'b1, 1'b1, 3'd4, 48'hF48F_BFBF_0000},
		'{16'hDC00, 1'b0, 1'b1, 3'd3, 48'hEFBF_BD00_0000},
		'{16'hD800, 1'b1, 1'b1, 3'd3, 48'hEFBF_BD00_0000},
		'{16'hD9AB, 1'b0, 1'b1, 3'd0, 48'h0000_0000_0000},
		'{16'h0041, 1'b0, 1'b1, 3'd4, 48'hEFBF_BD41_0000},
		'{16'hDA00, 1'b0, 1'b1, 3'd0, 48'h0000_0000_0000},
		'{16'hFFFF, 1'b1, 1'b1, 3'd6, 48'hEFBF_BDEF_BFBF},
		'{16'hDB00, 1'b0, 1'b1, 3'd0, 48'h0000_0000_0000},
		'{16'hDBFF, 1'b1, 1'b1, 3'd6, 48'hEFBF_BDEF_BFBD},
		'{16'hDA12, 1'b0, 1'b1, 3'd0, 48'h0000_0000_0000},
		'{16'hD834, 1'b0, 1'b1, 3'd3, 48'hEFBF_BD00_0000},
		'{16'hDD1E, 1'b1, 1'b0, 3'd0, 48'h0000_0000_0000},
		'{16'hE000, 1'b0, 1'b0, 3'd0, 48'h0000_0000_0000},
		'{16'h00E9, 1'b0, 1'b0, 3'd0, 48'h0000_0000_0000},
		'{16'hD7FF, 1'b0, 1'b0, 3'd0, 48'h0000_0000_0000},
		'{16'hDFFF, 1'b1, 1'b1, 3'd3, 48'hEFBF_BD00_0000}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] code_unit = '0;
	logic end_of_string = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_byte;
	logic run_last;

	logic [9:0] held_ten = '0;
	logic held_on = 1'b0;
	logic [7:0] word_bytes [$];
	utf8_out_t bytes_due [$];
	utf8_out_t due_now;

	int words_in = 0;
	int bytes_checked = 0;
	int pairs_joined = 0;
	int replacements = 0;
	int errors = 0;
	int quiet_cycles = 0;
	bit hold_done = 1'b0;
	bit drain_done = 1'b0;

	utf16_to_utf8_encoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_unit(code_unit),
		.end_of_string(end_of_string),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.run_last(run_last)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int pick_gap();
		int r;
		// a stretch of back-to-back traffic on both sides
		if (words_in >= N_DIR + 55 && words_in < N_DIR + 70)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 8);
		return $urandom_range(10, 30);
	endfunction

	function void put_byte(input logic [7:0] b);
		word_bytes = {word_bytes, b};
	endfunction

	function void add_due(input logic [7:0] b, input logic is_last);
		utf8_out_t e;
		e.data = b;
		e.last = is_last;
		bytes_due = {bytes_due, e};
	endfunction

	function void put_point(input logic [20:0] cp);
		if (cp <= uenc_pkg::MAX_ONE) begin
			put_byte(cp[7:0]);
		end else if (cp <= uenc_pkg::MAX_TWO) begin
			put_byte(uenc_pkg::LEAD_TWO | {3'b000, cp[10:6]});
			put_byte(uenc_pkg::CONT | {2'b00, cp[5:0]});
		end else if (cp <= uenc_pkg::MAX_THREE) begin
			put_byte(uenc_pkg::LEAD_THREE | {4'b0000, cp[15:12]});
			put_byte(uenc_pkg::CONT | {2'b00, cp[11:6]});
			put_byte(uenc_pkg::CONT | {2'b00, cp[5:0]});
		end else begin
			put_byte(uenc_pkg::LEAD_FOUR | {5'b00000, cp[20:18]});
			put_byte(uenc_pkg::CONT | {2'b00, cp[17:12]});
			put_byte(uenc_pkg::CONT | {2'b00, cp[11:6]});
			put_byte(uenc_pkg::CONT | {2'b00, cp[5:0]});
		end
	endfunction

	// utf-8 bytes that one code unit gives, with the held surrogate updated
	function void encode_unit(input logic [15:0] unit, input logic eos);
		logic is_high;
		logic is_low;
		is_high = unit >= uenc_pkg::HIGH_FIRST && unit <= uenc_pkg::HIGH_LAST;
		is_low = unit >= uenc_pkg::LOW_FIRST && unit <= uenc_pkg::LOW_LAST;
		word_bytes.delete();
		if (held_on && is_low) begin
			put_point(uenc_pkg::PLANE_BASE + {held_ten, 10'b0}
				+ 21'(unit - uenc_pkg::LOW_FIRST));
			held_on = 1'b0;
			held_ten = '0;
			pairs_joined++;
			return;
		end
		if (held_on) begin
			put_point(uenc_pkg::REPLACEMENT);
			held_on = 1'b0;
			held_ten = '0;
			replacements++;
		end
		if (is_high) begin
			if (eos) begin
				put_point(uenc_pkg::REPLACEMENT);
				replacements++;
			end else begin
				held_ten = unit[9:0];
				held_on = 1'b1;
			end
		end else if (is_low) begin
			put_point(uenc_pkg::REPLACEMENT);
			replacements++;
		end else begin
			put_point({5'b00000, unit});
		end
	endfunction

	task automatic offer_word(input logic [15:0] unit, input logic eos, input logic typed,
			input logic [2:0] count, input logic [47:0] bytes);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		code_unit <= unit;
		end_of_string <= eos;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_in++;
		encode_unit(unit, eos);
		if (typed) begin
			for (int i = 0; i < count; i++)
				add_due(bytes[47 - 8 * i -: 8], i == count - 1);
		end else begin
			for (int i = 0; i < word_bytes.size(); i++)
				add_due(word_bytes[i], i == word_bytes.size() - 1);
		end
	endtask

	task automatic offer_random_seq();
		int kind;
		logic eos;
		logic [15:0] unit;
		kind = $urandom_range(0, 99);
		eos = $urandom_range(0, 7) == 0;
		if (kind < 20) begin
			offer_word(16'($urandom_range(0, 16'h007F)), eos, 1'b0, 3'd0, '0);
		end else if (kind < 35) begin
			offer_word(16'($urandom_range(16'h0080, 16'h07FF)), eos, 1'b0, 3'd0, '0);
		end else if (kind < 55) begin
			// three-byte range with the surrogate block skipped
			unit = 16'($urandom_range(16'h0800, 16'hF7FF));
			if (unit >= uenc_pkg::HIGH_FIRST)
				unit = unit + 16'h0800;
			offer_word(unit, eos, 1'b0, 3'd0, '0);
		end else if (kind < 75) begin
			offer_word(16'($urandom_range(uenc_pkg::HIGH_FIRST, uenc_pkg::HIGH_LAST)),
				1'b0, 1'b0, 3'd0, '0);
			offer_word(16'($urandom_range(uenc_pkg::LOW_FIRST, uenc_pkg::LOW_LAST)),
				eos, 1'b0, 3'd0, '0);
		end else if (kind < 85) begin
			offer_word(16'($urandom_range(0, 16'hFFFF)), eos, 1'b0, 3'd0, '0);
		end else if (kind < 90) begin
			offer_word(16'($urandom_range(uenc_pkg::LOW_FIRST, uenc_pkg::LOW_LAST)),
				eos, 1'b0, 3'd0, '0);
		end else if (kind < 95) begin
			offer_word(16'($urandom_range(uenc_pkg::HIGH_FIRST, uenc_pkg::HIGH_LAST)),
				1'b0, 1'b0, 3'd0, '0);
			offer_word(16'($urandom_range(0, 16'hFFFF)), eos, 1'b0, 3'd0, '0);
		end else begin
			offer_word(16'($urandom_range(uenc_pkg::HIGH_FIRST, uenc_pkg::HIGH_LAST)),
				1'b1, 1'b0, 3'd0, '0);
		end
	endtask

	task automatic report_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	// receiver: random stalls plus one long hold-off while words keep coming
	initial begin
		int n;
		@(posedge clk);
		forever begin
			if (!hold_done && words_in >= N_DIR + 30) begin
				hold_done = 1'b1;
				n = LONG_HOLD;
			end else begin
				n = pick_gap();
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (out_valid && !out_stall) begin
				bytes_checked++;
				if (bytes_due.size() == 0) begin
					report_error($sformatf("unexpected byte %02h last %0b", out_byte, run_last));
				end else begin
					due_now = bytes_due.pop_front();
					if (out_byte !== due_now.data || run_last !== due_now.last)
						report_error($sformatf("byte %0d: expected %02h last %0b, got %02h last %0b",
							bytes_checked, due_now.data, due_now.last, out_byte, run_last));
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_utf16_to_utf8_encoder: done, errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int r = 0; r < N_DIR; r++)
			offer_word(DIR_ROWS[r].unit, DIR_ROWS[r].eos, DIR_ROWS[r].typed,
				DIR_ROWS[r].count, DIR_ROWS[r].bytes);
		while (words_in < N_DIR + RANDOM_WORDS) begin
			if (!drain_done && words_in >= N_DIR + 50) begin
				// sender waits for every byte to come out
				drain_done = 1'b1;
				in_valid <= 1'b0;
				wait (bytes_due.size() == 0);
				@(posedge clk);
			end
			offer_random_seq();
		end
		in_valid <= 1'b0;
		wait (bytes_due.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d words in, %0d bytes checked, %0d surrogate pairs, %0d replacements",
			words_in, bytes_checked, pairs_joined, replacements);
		if (errors == 0)
			$display("tb_utf16_to_utf8_encoder: done, clean");
		else
			$display("tb_utf16_to_utf8_encoder: done, errors");
		$finish;
	end

endmodule

FILE: files.f
src/uenc_pkg.sv
src/uenc_front.sv
src/uenc_fifo.sv
src/uenc_back.sv
src/utf16_to_utf8_encoder.sv
tb/tb_utf16_to_utf8_encoder.sv
